// File: sv/assert_macros.svh
// Assertion macros for the pose integrator RTL.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// File: sv/ddpi_pkg.sv
// Types, constants and small functions of the pose integrator.
// No dependencies.
package ddpi_pkg;

    typedef struct packed {
        logic               kind;
        logic signed [15:0] commanded_speed;
        logic signed [15:0] commanded_yaw_rate;
        logic        [15:0] elapsed_us;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] pose_x;
        logic signed [31:0] pose_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
        logic signed [15:0] speed_echo;
        logic signed [15:0] yaw_rate_echo;
        logic signed [15:0] acceleration;
        logic               accel_valid;
    } out_item_t;

    localparam logic [1:0]  CFG_START_X       = 2'd0;
    localparam logic [1:0]  CFG_START_Y       = 2'd1;
    localparam logic [1:0]  CFG_START_HEADING = 2'd2;

    localparam logic        KIND_LOAD  = 1'b1;

    localparam logic [63:0] HEAD_K     = 64'd716770142;
    localparam logic [33:0] CORDIC_X0  = 34'd652032874;
    // ceil(2^48 / 15625): exact floor division by 15625 below 2^34
    localparam logic [63:0] POS_RECIP  = 64'd18014398510;
    localparam logic [63:0] POS_HALF   = 64'd2097152000000;
    localparam logic [19:0] ACC_SCALE  = 20'd1000000;
    localparam logic [6:0]  DIV_BITS   = 7'd64;
    localparam int          MAX_STEPS  = 24;

    function automatic logic [31:0] ddpi_atan(input logic [4:0] i);
        logic [31:0] r;
        case (i)
            5'd0:    r = 32'h20000000;
            5'd1:    r = 32'h12E4051D;
            5'd2:    r = 32'h09FB385B;
            5'd3:    r = 32'h051111D4;
            5'd4:    r = 32'h028B0D43;
            5'd5:    r = 32'h0145D7E1;
            5'd6:    r = 32'h00A2F61E;
            5'd7:    r = 32'h00517C55;
            5'd8:    r = 32'h0028BE53;
            5'd9:    r = 32'h00145F2E;
            5'd10:   r = 32'h000A2F98;
            5'd11:   r = 32'h000517CC;
            5'd12:   r = 32'h00028BE6;
            5'd13:   r = 32'h000145F3;
            5'd14:   r = 32'h0000A2F9;
            5'd15:   r = 32'h0000517C;
            5'd16:   r = 32'h000028BE;
            5'd17:   r = 32'h0000145F;
            5'd18:   r = 32'h00000A2F;
            5'd19:   r = 32'h00000517;
            5'd20:   r = 32'h0000028B;
            5'd21:   r = 32'h00000145;
            5'd22:   r = 32'h000000A2;
            5'd23:   r = 32'h00000051;
            default: r = 32'h0;
        endcase
        return r;
    endfunction

    // Q1.30 to Q1.14, ties up, clamped
    function automatic logic signed [15:0] ddpi_quat(input logic signed [33:0] v);
        logic signed [34:0] t;
        logic signed [18:0] q;
        logic signed [15:0] r;
        t = 35'(v) + 35'sd32768;
        q = 19'(t >>> 16);
        if (q > 19'sd16384)
            r = 16'sd16384;
        else if (q < -19'sd16384)
            r = -16'sd16384;
        else
            r = 16'(q);
        return r;
    endfunction

endpackage

// File: sv/diff_drive_pose_integrator.sv
// Differential-drive pose integrator: Euler steps with CORDIC sin and cos.
// Depends on ddpi_pkg and assert_macros.svh.
//
//  channel  | signals                          | carries
//  in       | in_valid, in_ready, in_data      | tick or load request
//  out      | out_valid, out_ready, out_data   | pose, quaternion, echoes, acceleration
//  cfg      | cfg_we, cfg_index, cfg_data      | start pose registers
//
// A tick runs the shared shift-add multiplier (heading product; per axis speed,
// dt and two reciprocal products), the 64-step acceleration divider when elapsed_us
// is nonzero, and the CORDIC loop twice.
// A load runs the CORDIC loop once. in_ready is high only while idle.
// A finished result waits in the output register; a new request is taken
// meanwhile, and its result holds in S_FIN until the register is free.
// Reset clears pose, heading, previous speed and start registers.
`include "assert_macros.svh"
module diff_drive_pose_integrator
    import ddpi_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_data,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int STEPS = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;

    typedef enum logic [14:0] {
        S_IDLE   = 15'b000000000000001,
        S_HMUL   = 15'b000000000000010,
        S_HUPD   = 15'b000000000000100,
        S_CORD   = 15'b000000000001000,
        S_PSET   = 15'b000000000010000,
        S_PMUL1  = 15'b000000000100000,
        S_PMUL2  = 15'b000000001000000,
        S_PREC1  = 15'b000000010000000,
        S_PREC2  = 15'b000000100000000,
        S_PUPD   = 15'b000001000000000,
        S_ADIV   = 15'b000010000000000,
        S_AUPD   = 15'b000100000000000,
        S_QSTART = 15'b001000000000000,
        S_QCORD  = 15'b010000000000000,
        S_FIN    = 15'b100000000000000
    } state_t;

    state_t             state_reg;
    in_item_t           in_reg;
    out_item_t          out_reg;
    logic               out_valid_reg;
    logic [31:0]        start_x_reg, start_y_reg, start_h_reg;
    logic [31:0]        pos_x_reg, pos_y_reg, heading_reg;
    logic signed [15:0] prev_speed_reg;
    logic [63:0]        op_a_reg, op_b_reg, acc_reg;
    logic [16:0]        nh_reg;
    logic               neg_reg;
    logic [6:0]         cnt_reg;
    logic signed [33:0] cx_reg, cy_reg, ca_reg;
    logic               flip_reg;
    logic [4:0]         ci_reg;
    logic               axis_reg;
    logic signed [15:0] accel_reg;
    logic               accel_ok_reg;

    logic               accept;
    logic signed [32:0] wdt;
    logic [32:0]        wdt_mag;
    logic [63:0]        prod_s, prod_rnd;
    logic [31:0]        head_new, cor_angle;
    logic signed [33:0] cor_a0;
    logic               cor_flip0;
    logic signed [33:0] xs, ys, at, nx, ny, na;
    logic               cor_last;
    logic [63:0]        rem_sh;
    logic               rem_ge;
    logic signed [33:0] c_sel;
    logic [33:0]        c_mag;
    logic [16:0]        v_mag;
    logic signed [16:0] diff;
    logic [16:0]        diff_mag;
    logic [36:0]        diff_scaled;
    logic [63:0]        pos_n;
    logic [31:0]        q_signed;

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        wdt      = $signed(in_data.commanded_yaw_rate) * $signed({1'b0, in_data.elapsed_us});
        wdt_mag  = wdt[32] ? 33'(-wdt) : 33'(wdt);
        prod_s   = neg_reg ? (64'd0 - acc_reg) : acc_reg;
        prod_rnd = prod_s + 64'h8000_0000;
        head_new = heading_reg + prod_rnd[63:32];
        cor_angle = (state_reg == S_HUPD) ? head_new : {1'b0, heading_reg[31:1]};
        cor_a0    = {{2{cor_angle[31]}}, cor_angle};
        cor_flip0 = 1'b0;
        if (cor_a0 > 34'sd1073741824)
        begin
            cor_a0    = cor_a0 - 34'sd2147483648;
            cor_flip0 = 1'b1;
        end
        else if (cor_a0 < -34'sd1073741824)
        begin
            cor_a0    = cor_a0 + 34'sd2147483648;
            cor_flip0 = 1'b1;
        end
        xs = cx_reg >>> ci_reg;
        ys = cy_reg >>> ci_reg;
        at = $signed({2'b00, ddpi_atan(ci_reg)});
        if (!ca_reg[33])
        begin
            nx = cx_reg - ys;
            ny = cy_reg + xs;
            na = ca_reg - at;
        end
        else
        begin
            nx = cx_reg + ys;
            ny = cy_reg - xs;
            na = ca_reg + at;
        end
        cor_last = (ci_reg == 5'(STEPS - 1));
        if (cor_last && flip_reg)
        begin
            nx = -nx;
            ny = -ny;
        end
        rem_sh   = {acc_reg[62:0], op_a_reg[63]};
        rem_ge   = (rem_sh >= op_b_reg);
        c_sel    = axis_reg ? cy_reg : cx_reg;
        c_mag    = c_sel[33] ? 34'(-c_sel) : 34'(c_sel);
        v_mag    = in_reg.commanded_speed[15] ? 17'(-17'(in_reg.commanded_speed))
                                              : 17'(in_reg.commanded_speed);
        diff     = 17'(in_reg.commanded_speed) - 17'(prev_speed_reg);
        diff_mag = diff[16] ? 17'(-diff) : 17'(diff);
        diff_scaled = 37'(diff_mag) * 37'(ACC_SCALE);
        // rounded product; /2^28 by bit select, /15625 by reciprocal in two halves
        pos_n    = acc_reg + POS_HALF;
        q_signed = neg_reg ? (32'd0 - acc_reg[62:31]) : acc_reg[62:31];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            start_x_reg    <= '0;
            start_y_reg    <= '0;
            start_h_reg    <= '0;
            pos_x_reg      <= '0;
            pos_y_reg      <= '0;
            heading_reg    <= '0;
            prev_speed_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_START_X:       start_x_reg <= cfg_data;
                    CFG_START_Y:       start_y_reg <= cfg_data;
                    CFG_START_HEADING: start_h_reg <= cfg_data;
                    default:           ;
                endcase
            end
            if (out_valid_reg && out_ready && (state_reg != S_FIN))
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        in_reg       <= in_data;
                        accel_reg    <= '0;
                        accel_ok_reg <= 1'b0;
                        if (in_data.kind == KIND_LOAD)
                        begin
                            pos_x_reg   <= start_x_reg;
                            pos_y_reg   <= start_y_reg;
                            heading_reg <= start_h_reg;
                            state_reg   <= S_QSTART;
                        end
                        else
                        begin
                            op_a_reg  <= 64'(wdt_mag);
                            op_b_reg  <= HEAD_K;
                            acc_reg   <= '0;
                            neg_reg   <= wdt[32];
                            state_reg <= S_HMUL;
                        end
                    end
                end
                S_HMUL, S_PMUL1, S_PMUL2, S_PREC1, S_PREC2:
                begin
                    if (op_b_reg == 64'd0)
                    begin
                        case (state_reg)
                            S_HMUL:  state_reg <= S_HUPD;
                            S_PMUL1:
                            begin
                                op_a_reg  <= acc_reg;
                                op_b_reg  <= 64'(in_reg.elapsed_us);
                                acc_reg   <= '0;
                                state_reg <= S_PMUL2;
                            end
                            S_PMUL2:
                            begin
                                op_a_reg  <= POS_RECIP;
                                op_b_reg  <= 64'(pos_n[44:28]);
                                nh_reg    <= pos_n[61:45];
                                acc_reg   <= '0;
                                state_reg <= S_PREC1;
                            end
                            S_PREC1:
                            begin
                                op_a_reg  <= POS_RECIP;
                                op_b_reg  <= 64'(nh_reg);
                                acc_reg   <= {17'd0, acc_reg[63:17]};
                                state_reg <= S_PREC2;
                            end
                            default: state_reg <= S_PUPD;
                        endcase
                    end
                    else
                    begin
                        if (op_b_reg[0])
                            acc_reg <= acc_reg + op_a_reg;
                        op_a_reg <= {op_a_reg[62:0], 1'b0};
                        op_b_reg <= {1'b0, op_b_reg[63:1]};
                    end
                end
                S_HUPD, S_QSTART:
                begin
                    if (state_reg == S_HUPD)
                        heading_reg <= head_new;
                    cx_reg    <= $signed(CORDIC_X0);
                    cy_reg    <= '0;
                    ca_reg    <= cor_a0;
                    flip_reg  <= cor_flip0;
                    ci_reg    <= '0;
                    axis_reg  <= 1'b0;
                    state_reg <= (state_reg == S_HUPD) ? S_CORD : S_QCORD;
                end
                S_CORD, S_QCORD:
                begin
                    cx_reg <= nx;
                    cy_reg <= ny;
                    ca_reg <= na;
                    ci_reg <= ci_reg + 5'd1;
                    if (cor_last)
                        state_reg <= (state_reg == S_CORD) ? S_PSET : S_FIN;
                end
                S_PSET:
                begin
                    op_a_reg  <= 64'(c_mag);
                    op_b_reg  <= 64'(v_mag);
                    acc_reg   <= '0;
                    neg_reg   <= c_sel[33] ^ in_reg.commanded_speed[15];
                    state_reg <= S_PMUL1;
                end
                S_ADIV:
                begin
                    acc_reg  <= rem_ge ? (rem_sh - op_b_reg) : rem_sh;
                    op_a_reg <= {op_a_reg[62:0], rem_ge};
                    cnt_reg  <= cnt_reg - 7'd1;
                    if (cnt_reg == 7'd1)
                        state_reg <= S_AUPD;
                end
                S_PUPD:
                begin
                    if (!axis_reg)
                    begin
                        pos_x_reg <= pos_x_reg + q_signed;
                        axis_reg  <= 1'b1;
                        state_reg <= S_PSET;
                    end
                    else
                    begin
                        pos_y_reg      <= pos_y_reg + q_signed;
                        prev_speed_reg <= in_reg.commanded_speed;
                        if (in_reg.elapsed_us != 16'd0)
                        begin
                            op_a_reg  <= 64'(diff_scaled) + 64'(in_reg.elapsed_us[15:1]);
                            op_b_reg  <= 64'(in_reg.elapsed_us);
                            acc_reg   <= '0;
                            neg_reg   <= diff[16];
                            cnt_reg   <= DIV_BITS;
                            state_reg <= S_ADIV;
                        end
                        else
                            state_reg <= S_QSTART;
                    end
                end
                S_AUPD:
                begin
                    accel_ok_reg <= 1'b1;
                    if (!neg_reg)
                        accel_reg <= (op_a_reg > 64'd32767) ? 16'sd32767 : 16'(op_a_reg);
                    else
                        accel_reg <= (op_a_reg > 64'd32768) ? -16'sd32768
                                                            : 16'(64'd0 - op_a_reg);
                    state_reg <= S_QSTART;
                end
                S_FIN:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_reg.pose_x        <= pos_x_reg;
                        out_reg.pose_y        <= pos_y_reg;
                        out_reg.quat_z        <= ddpi_quat(cy_reg);
                        out_reg.quat_w        <= ddpi_quat(cx_reg);
                        out_reg.speed_echo    <= in_reg.commanded_speed;
                        out_reg.yaw_rate_echo <= in_reg.commanded_yaw_rate;
                        out_reg.acceleration  <= accel_reg;
                        out_reg.accel_valid   <= accel_ok_reg;
                        out_valid_reg         <= 1'b1;
                        state_reg             <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `ASSERT_NEXT(a_busy_after_req, accept, !in_ready)
    `ASSERT_IMPL(a_cordic_index, (state_reg == S_CORD) || (state_reg == S_QCORD), ci_reg < 5'(STEPS))
    `ASSERT_IMPL(a_recip_high, state_reg == S_PREC2, op_b_reg[63:17] == '0)
    `ASSERT_IMPL(a_accel_zero, out_valid_reg && !out_reg.accel_valid, out_reg.acceleration == 16'sd0)

endmodule
